// ===== design/complex_arith_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Shared concurrent assertion forms for the complex arithmetic unit checks.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Checked property with the reset masking the check.
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds while reset is high.
`define CAU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, codes, item types and the divider step shared by the unit files.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Word and fraction widths of the Q format.
  localparam int W = 32;
  localparam int F = 16;

  // Derived datapath widths.
  localparam int AW = W + 1;       // add and subtract results
  localparam int PW = 2 * W;       // one product
  localparam int SW = PW + 1;      // sum of two products
  localparam int DW = PW;          // divisor, br^2 + bi^2
  localparam int NW = SW + F;      // shifted dividend magnitude, also quotient bits
  localparam int VW = NW + 1;      // signed result before the bounds check

  localparam int CFG_IDX_BITS = 1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MIN = 1'b0,
    CFG_MAX = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]            kind;
    logic signed [W-1:0]   a_real;
    logic signed [W-1:0]   a_imag;
    logic signed [W-1:0]   b_real;
    logic signed [W-1:0]   b_imag;
  } in_item_t;

  typedef struct packed {
    logic signed [W-1:0]   res_real;
    logic signed [W-1:0]   res_imag;
    logic [1:0]            status;
  } out_item_t;

  // One restoring divider lane: partial remainder and the dividend bits
  // that shift out on the left while quotient bits shift in on the right.
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [NW-1:0] nq;
  } lane_t;

  typedef struct packed {
    lane_t                re;
    lane_t                im;
    logic [DW-1:0]        den;
    logic                 neg_re;
    logic                 neg_im;
    logic                 is_div;
    logic                 dz;
    logic signed [VW-1:0] val_re;
    logic signed [VW-1:0] val_im;
    logic                 x_re;
    logic                 x_im;
  } dstage_t;

  // One quotient bit of a lane.
  function automatic lane_t lane_step(lane_t s, logic [DW-1:0] den);
    lane_t       r;
    logic [DW:0] t;
    logic [DW:0] d;
    logic        qb;
    t  = {s.rem, s.nq[NW-1]};
    d  = {1'b0, den};
    qb = (t >= d);
    if (qb) begin
      t = t - d;
    end
    r.rem = t[DW-1:0];
    r.nq  = {s.nq[NW-2:0], qb};
    return r;
  endfunction

  // One divider stage: both lanes share the divisor.
  function automatic dstage_t div_step(dstage_t s);
    dstage_t r;
    r    = s;
    r.re = lane_step(s.re, s.den);
    r.im = lane_step(s.im, s.den);
    return r;
  endfunction

  // Signed floor of a lane result; the sign comes from the dividend.
  function automatic logic signed [VW-1:0] lane_floor(lane_t s, logic neg);
    logic [VW-1:0] ext;
    logic          inx;
    ext = {1'b0, s.nq};
    inx = |s.rem;
    return neg ? $signed(~ext + VW'(!inx)) : $signed(ext);
  endfunction

  // Bounds test on the floor value; the inexact flag makes a value equal to
  // the upper bound overflow.
  function automatic status_e check_part(logic signed [VW-1:0] v, logic x,
                                         logic signed [W-1:0] lo,
                                         logic signed [W-1:0] hi);
    logic signed [VW-1:0] lo_w;
    logic signed [VW-1:0] hi_w;
    lo_w = VW'(lo);
    hi_w = VW'(hi);
    if (v < lo_w) begin
      return ST_UNDER;
    end else if ((v > hi_w) || ((v == hi_w) && x)) begin
      return ST_OVER;
    end
    return ST_OK;
  endfunction

endpackage

// ===== design/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply or divide of two Q16.16 complex operands with a
// bounds check on each result part.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake             Payload
//  --------  --------------------  ---------------------------------------
//  input     in_valid / in_ready   in_item  (kind, a_real, a_imag, b_real, b_imag)
//  output    out_valid / out_ready out_item (res_real, res_imag, status)
//  config    cfg_we                cfg_index, cfg_data (min_value, max_value)
//
// One item is taken per cycle while the skid slot is empty. The restoring
// divider resolves one quotient bit per stage, for NW bits (81 at Q16.16).
// Reset clears all valid bits and loads the widest bounds.
// A stalled output holds one result and takes one more into a skid slot;
// the pipeline stops only when both are full.

module complex_arith_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  cau_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output cau_pkg::out_item_t                out_item,
  input  logic                              cfg_we,
  input  logic [cau_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cau_pkg::W-1:0]             cfg_data
);

  // Bound registers.
  logic signed [cau_pkg::W-1:0] min_value;
  logic signed [cau_pkg::W-1:0] max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_value <= {1'b1, {(cau_pkg::W-1){1'b0}}};
      max_value <= {1'b0, {(cau_pkg::W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cau_pkg::cfg_idx_e'(cfg_index))
        cau_pkg::CFG_MIN: min_value <= $signed(cfg_data);
        cau_pkg::CFG_MAX: max_value <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Whole pipeline advances while the skid slot is empty.
  logic en;
  logic s_valid;

  assign en       = !s_valid;
  assign in_ready = en;

  // Stage 1: products and add/subtract.
  logic                          s1_valid;
  logic [1:0]                    s1_kind;
  logic signed [cau_pkg::PW-1:0] p_rr, p_ii, p_ir, p_ri, p_bbr, p_bbi;
  logic signed [cau_pkg::AW-1:0] s1_as_re, s1_as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_kind <= in_item.kind;
      p_rr    <= in_item.a_real * in_item.b_real;
      p_ii    <= in_item.a_imag * in_item.b_imag;
      p_ir    <= in_item.a_imag * in_item.b_real;
      p_ri    <= in_item.a_real * in_item.b_imag;
      p_bbr   <= in_item.b_real * in_item.b_real;
      p_bbi   <= in_item.b_imag * in_item.b_imag;
      if (in_item.kind == cau_pkg::KIND_SUB) begin
        s1_as_re <= cau_pkg::AW'(in_item.a_real) - cau_pkg::AW'(in_item.b_real);
        s1_as_im <= cau_pkg::AW'(in_item.a_imag) - cau_pkg::AW'(in_item.b_imag);
      end else begin
        s1_as_re <= cau_pkg::AW'(in_item.a_real) + cau_pkg::AW'(in_item.b_real);
        s1_as_im <= cau_pkg::AW'(in_item.a_imag) + cau_pkg::AW'(in_item.b_imag);
      end
    end
  end

  // Stage 2: product sums and the divisor.
  logic                          s2_valid;
  logic [1:0]                    s2_kind;
  logic signed [cau_pkg::SW-1:0] s2_re, s2_im;
  logic [cau_pkg::DW-1:0]        s2_den;
  logic signed [cau_pkg::AW-1:0] s2_as_re, s2_as_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_kind  <= s1_kind;
      s2_as_re <= s1_as_re;
      s2_as_im <= s1_as_im;
      s2_den   <= $unsigned(p_bbr) + $unsigned(p_bbi);
      if (s1_kind == cau_pkg::KIND_DIV) begin
        s2_re <= cau_pkg::SW'(p_rr) + cau_pkg::SW'(p_ii);
        s2_im <= cau_pkg::SW'(p_ir) - cau_pkg::SW'(p_ri);
      end else begin
        s2_re <= cau_pkg::SW'(p_rr) - cau_pkg::SW'(p_ii);
        s2_im <= cau_pkg::SW'(p_ir) + cau_pkg::SW'(p_ri);
      end
    end
  end

  // Divider entry: dividend magnitudes, and the finished values of the
  // other operations, which ride along unchanged.
  localparam logic [cau_pkg::SW-1:0] FRAC_MASK =
    (cau_pkg::SW'(1) << cau_pkg::F) - cau_pkg::SW'(1);

  cau_pkg::dstage_t       prep;
  logic [cau_pkg::SW-1:0] mag_re, mag_im;

  always_comb begin
    mag_re = s2_re[cau_pkg::SW-1] ? $unsigned(-s2_re) : $unsigned(s2_re);
    mag_im = s2_im[cau_pkg::SW-1] ? $unsigned(-s2_im) : $unsigned(s2_im);
    prep.re.rem = '0;
    prep.im.rem = '0;
    prep.re.nq  = cau_pkg::NW'(mag_re) << cau_pkg::F;
    prep.im.nq  = cau_pkg::NW'(mag_im) << cau_pkg::F;
    prep.den    = s2_den;
    prep.neg_re = s2_re[cau_pkg::SW-1];
    prep.neg_im = s2_im[cau_pkg::SW-1];
    prep.is_div = (s2_kind == cau_pkg::KIND_DIV);
    prep.dz     = (s2_kind == cau_pkg::KIND_DIV) && (s2_den == '0);
    if (s2_kind == cau_pkg::KIND_MUL) begin
      prep.val_re = cau_pkg::VW'(s2_re >>> cau_pkg::F);
      prep.val_im = cau_pkg::VW'(s2_im >>> cau_pkg::F);
      prep.x_re   = |(s2_re & FRAC_MASK);
      prep.x_im   = |(s2_im & FRAC_MASK);
    end else begin
      prep.val_re = cau_pkg::VW'(s2_as_re);
      prep.val_im = cau_pkg::VW'(s2_as_im);
      prep.x_re   = 1'b0;
      prep.x_im   = 1'b0;
    end
  end

  // Divider pipeline: one quotient bit per stage.
  logic [cau_pkg::NW:0] dv;
  cau_pkg::dstage_t     ds [cau_pkg::NW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[cau_pkg::NW-1:0], s2_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= prep;
      for (int i = 1; i <= cau_pkg::NW; i++) begin
        ds[i] <= cau_pkg::div_step(ds[i-1]);
      end
    end
  end

  // Signed floor of the quotients, or the values carried along.
  logic                          sa_valid;
  logic signed [cau_pkg::VW-1:0] sa_re, sa_im;
  logic                          sa_xre, sa_xim, sa_dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_valid <= 1'b0;
    end else if (en) begin
      sa_valid <= dv[cau_pkg::NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_dz <= ds[cau_pkg::NW].dz;
      if (ds[cau_pkg::NW].is_div) begin
        sa_re  <= cau_pkg::lane_floor(ds[cau_pkg::NW].re, ds[cau_pkg::NW].neg_re);
        sa_im  <= cau_pkg::lane_floor(ds[cau_pkg::NW].im, ds[cau_pkg::NW].neg_im);
        sa_xre <= |ds[cau_pkg::NW].re.rem;
        sa_xim <= |ds[cau_pkg::NW].im.rem;
      end else begin
        sa_re  <= ds[cau_pkg::NW].val_re;
        sa_im  <= ds[cau_pkg::NW].val_im;
        sa_xre <= ds[cau_pkg::NW].x_re;
        sa_xim <= ds[cau_pkg::NW].x_im;
      end
    end
  end

  // Bounds check: real part first, underflow before overflow.
  cau_pkg::status_e   st;
  cau_pkg::out_item_t push_item;
  logic               push;

  always_comb begin
    if (sa_dz) begin
      st = cau_pkg::ST_DIVZ;
    end else begin
      st = cau_pkg::check_part(sa_re, sa_xre, min_value, max_value);
      if (st == cau_pkg::ST_OK) begin
        st = cau_pkg::check_part(sa_im, sa_xim, min_value, max_value);
      end
    end
    push_item.status = st;
    if (st == cau_pkg::ST_OK) begin
      push_item.res_real = sa_re[cau_pkg::W-1:0];
      push_item.res_imag = sa_im[cau_pkg::W-1:0];
    end else begin
      push_item.res_real = '0;
      push_item.res_imag = '0;
    end
  end

  assign push = en && sa_valid;

  // Output register with one skid slot behind it.
  logic               o_valid;
  logic               pop;
  cau_pkg::out_item_t o_item, s_item;

  assign pop = o_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (!o_valid || pop) begin
      if (s_valid) begin
        o_valid <= 1'b1;
        o_item  <= s_item;
        s_valid <= 1'b0;
      end else begin
        o_valid <= push;
        o_item  <= push_item;
      end
    end else if (push) begin
      s_valid <= 1'b1;
      s_item  <= push_item;
    end
  end

  assign out_valid = o_valid;
  assign out_item  = o_item;

endmodule

// ===== design/cau_checker.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level assertions on the complex arithmetic unit, bound to its top.
// ----------------------------------------------------------------------------
`include "complex_arith_unit_defines.svh"

module cau_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input cau_pkg::out_item_t out_item
);

  // A failed check or a zero divisor always comes with a zero result.
  `CAU_ASSERT(a_zero_on_error, out_valid && (out_item.status != cau_pkg::ST_OK) |-> (out_item.res_real == '0) && (out_item.res_imag == '0), "nonzero result with error status")

  // The input side only stalls while a result is waiting at the output.
  `CAU_ASSERT(a_stall_cause, !in_ready |-> out_valid, "input stalled with no result waiting")

  // A result that is not taken stays put.
  `CAU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "output result changed while stalled")

  // Reset empties the pipeline and opens the input.
  `CAU_ASSERT_RST(a_reset_empty, rst |=> !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind complex_arith_unit cau_checker u_cau_checker (.*);
